@@ rtl/dcbp_pkg.sv @@
// Package for the display command byte parser: types, constants and decode helpers.
package dcbp_pkg;

  localparam logic [7:0] ChZero = "0";
  localparam logic [7:0] ChFive = "5";
  localparam logic [7:0] ChNine = "9";
  localparam logic [7:0] ChStar = "*";
  localparam logic [7:0] ChQuery = "?";
  localparam logic [6:0] HexBaseReset = 7'd65;
  localparam logic [3:0] HexLetterCount = 4'd6;
  localparam logic [4:0] HexTen = 5'd10;
  localparam int unsigned ParamDepth = 3;

  typedef enum logic [4:0] {
    ACT_NONE     = 5'd0,
    ACT_SETCHAR  = 5'd1,
    ACT_BLANK    = 5'd2,
    ACT_CUSTOM   = 5'd3,
    ACT_DIM      = 5'd4,
    ACT_FLIP     = 5'd5,
    ACT_INVERT   = 5'd6,
    ACT_PALETTE  = 5'd7,
    ACT_MIRROR   = 5'd8,
    ACT_COPY     = 5'd9,
    ACT_ROLL     = 5'd10,
    ACT_SHIFT    = 5'd11,
    ACT_PIXEL    = 5'd12,
    ACT_RESET    = 5'd13,
    ACT_COLUMN   = 5'd14,
    ACT_WATCHDOG = 5'd15,
    ACT_DUMP     = 5'd16
  } action_e;

  typedef struct packed {
    logic [7:0] echo_byte;
    action_e    action;
    logic       display_select;
    logic       on_flag;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic [7:0] arg_c;
  } result_t;

  // Parameter count of a command byte, 0 when the byte takes no parameters or is not a command.
  function automatic logic [1:0] params_for(input logic [7:0] c);
    logic [1:0] n;
    case (c)
      "a", "A", "b", "B", "c", "C", "d", "D", "f", "F",
      "i", "I", "m", "M", "R", "!":                        n = 2'd1;
      "p", "P", "l", "L", "0", "1", "2", "3", "4",
      "5", "6", "7", "8", "9":                              n = 2'd2;
      "r", "s", "t", "T":                                   n = 2'd3;
      default:                                              n = 2'd0;
    endcase
    return n;
  endfunction

  // One hex digit; unknown digits read as 0.
  function automatic logic [3:0] nibble_of(input logic [7:0] c, input logic [6:0] base);
    logic [8:0] diff;
    logic [7:0] dig;
    logic [3:0] nib;
    diff = {1'b0, c} - {2'b00, base};
    dig  = c - ChZero;
    if (c >= ChZero && c <= ChNine) begin
      nib = dig[3:0];
    end else if (!diff[8] && diff < {5'd0, HexLetterCount}) begin
      nib = diff[3:0] + HexTen[3:0];
    end else begin
      nib = 4'd0;
    end
    return nib;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo,
                                          input logic [6:0] base);
    return {nibble_of(hi, base), nibble_of(lo, base)};
  endfunction

endpackage

@@ rtl/dcbp_in_if.sv @@
// Input channel: received bytes with valid/ready handshake.
interface dcbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/dcbp_out_if.sv @@
// Output channel: echoed byte and decoded display action with valid/ready handshake.
interface dcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [4:0] action;
  logic       display_select;
  logic       on_flag;
  logic [7:0] arg_a;
  logic [7:0] arg_b;
  logic [7:0] arg_c;

  modport source (output valid, output echo_byte, output action, output display_select,
                  output on_flag, output arg_a, output arg_b, output arg_c, input ready);
  modport sink (input valid, input echo_byte, input action, input display_select,
                input on_flag, input arg_a, input arg_b, input arg_c, output ready);
endinterface

@@ rtl/display_command_byte_parser_unit.sv @@
// Top level: display command byte parser, one byte in and one result out per transaction.
//
//  channel          dir  handshake      payload
//  rx_i             in   valid/ready    rx_byte
//  tx_o             out  valid/ready    echo_byte, action, display_select, on_flag, arg_a..c
//  hex_letter_base  in   write enable   7-bit letter base for hex digits
//
// One byte per cycle unless the output stalls; input register, then result register.
// The parser state updates as a byte moves from the input register to the result register.
// Reset clears the pending command, counters, valids and sets the letter base to 'A'.
// A stalled output holds the result; the input register still takes a byte if it is empty.
module display_command_byte_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcbp_in_if.sink    rx_i,
  dcbp_out_if.source tx_o,
  input  logic       hex_letter_base_we_i,
  input  logic [6:0] hex_letter_base_i
);

  logic [6:0]          hex_base_q;
  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_valid_q;
  dcbp_pkg::result_t   res_q, res_d;
  logic [7:0]          pending_q, pending_d;
  logic [1:0]          left_q, left_d;
  logic [1:0]          pos_q, pos_d;
  logic [7:0]          store_q [dcbp_pkg::ParamDepth];
  logic [7:0]          p0, p1, p2;
  logic                advance;
  logic                step;
  logic                which;
  logic [1:0]          n_params;
  logic [7:0]          col_off;

  assign advance    = !out_valid_q || tx_o.ready;
  assign step       = advance && in_valid_q;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_base_q <= dcbp_pkg::HexBaseReset;
    end else if (hex_letter_base_we_i) begin
      hex_base_q <= hex_letter_base_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Parameters as seen at completion, with the current byte folded in.
  assign p0 = (pos_q == 2'd0) ? in_byte_q : store_q[0];
  assign p1 = (pos_q == 2'd1) ? in_byte_q : store_q[1];
  assign p2 = (pos_q == 2'd2) ? in_byte_q : store_q[2];
  assign which    = (p0 != dcbp_pkg::ChZero);
  assign n_params = dcbp_pkg::params_for(in_byte_q);
  assign col_off  = pending_q - ((pending_q > "4") ? dcbp_pkg::ChFive : dcbp_pkg::ChZero);

  always_comb begin
    pending_d = pending_q;
    left_d    = left_q;
    pos_d     = pos_q;
    res_d     = '0;
    res_d.echo_byte = in_byte_q;
    res_d.action    = dcbp_pkg::ACT_NONE;
    if (pending_q != 8'd0) begin
      left_d = left_q - 2'd1;
      pos_d  = pos_q + 2'd1;
      if (left_d == 2'd0) begin
        pending_d = 8'd0;
        pos_d     = 2'd0;
        case (pending_q)
          "a", "A": begin
            res_d.action         = dcbp_pkg::ACT_SETCHAR;
            res_d.display_select = (pending_q == "A");
            res_d.arg_a          = p0;
          end
          "b", "B", "c", "C", "d", "D", "f", "F", "i", "I", "m", "M": begin
            case (pending_q)
              "b", "B": res_d.action = dcbp_pkg::ACT_BLANK;
              "c", "C": res_d.action = dcbp_pkg::ACT_CUSTOM;
              "d", "D": res_d.action = dcbp_pkg::ACT_DIM;
              "f", "F": res_d.action = dcbp_pkg::ACT_FLIP;
              "i", "I": res_d.action = dcbp_pkg::ACT_INVERT;
              default:  res_d.action = dcbp_pkg::ACT_MIRROR;
            endcase
            res_d.display_select = which;
            res_d.on_flag        = pending_q[5];
          end
          "l", "L", "p", "P": begin
            res_d.action = (pending_q == "l" || pending_q == "L") ?
                           dcbp_pkg::ACT_PALETTE : dcbp_pkg::ACT_COPY;
            res_d.display_select = !pending_q[5];
            res_d.arg_a          = dcbp_pkg::hex_pair(p0, p1, hex_base_q);
          end
          "r", "s": begin
            res_d.action = (pending_q == "r") ? dcbp_pkg::ACT_ROLL : dcbp_pkg::ACT_SHIFT;
            res_d.display_select = which;
            res_d.arg_a          = p1;
            res_d.arg_b          = p2 - dcbp_pkg::ChZero;
          end
          "t", "T": begin
            res_d.action         = dcbp_pkg::ACT_PIXEL;
            res_d.display_select = which;
            res_d.on_flag        = (pending_q == "t");
            res_d.arg_b          = p1 - dcbp_pkg::ChZero;
            res_d.arg_c          = p2 - dcbp_pkg::ChZero;
          end
          "!": begin
            res_d.action         = dcbp_pkg::ACT_RESET;
            res_d.display_select = which;
          end
          "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
            res_d.action         = dcbp_pkg::ACT_COLUMN;
            res_d.display_select = (pending_q > "4");
            res_d.arg_a          = dcbp_pkg::hex_pair(p0, p1, hex_base_q);
            res_d.arg_b          = col_off;
          end
          default: res_d.action = dcbp_pkg::ACT_NONE;
        endcase
      end
    end else begin
      left_d    = n_params;
      pos_d     = 2'd0;
      pending_d = (n_params != 2'd0) ? in_byte_q : 8'd0;
      if (n_params == 2'd0) begin
        if (in_byte_q == dcbp_pkg::ChStar) begin
          res_d.action = dcbp_pkg::ACT_WATCHDOG;
        end else if (in_byte_q == dcbp_pkg::ChQuery) begin
          res_d.action = dcbp_pkg::ACT_DUMP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 8'd0;
      left_q      <= 2'd0;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        pending_q <= pending_d;
        left_q    <= left_d;
        pos_q     <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
      if (pending_q != 8'd0 && pos_q != 2'd3) begin
        store_q[pos_q] <= in_byte_q;
      end
    end
  end

  assign tx_o.valid          = out_valid_q;
  assign tx_o.echo_byte      = res_q.echo_byte;
  assign tx_o.action         = res_q.action;
  assign tx_o.display_select = res_q.display_select;
  assign tx_o.on_flag        = res_q.on_flag;
  assign tx_o.arg_a          = res_q.arg_a;
  assign tx_o.arg_b          = res_q.arg_b;
  assign tx_o.arg_c          = res_q.arg_c;

  a_pending_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != 8'd0) == (left_q != 2'd0))
    else $error("pending command and parameter count disagree");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != 8'd0) |-> ({1'b0, pos_q} + {1'b0, left_q}) <= 3'd3)
    else $error("parameter position and count exceed three");

  a_action_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_d.action != dcbp_pkg::ACT_NONE) |=> (pending_q == 8'd0))
    else $error("command still pending after an action");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input register lost a byte under stall");

endmodule
